// File: design/rsph_pkg.sv
// Shared constants for the ray / sphere pixel hit test.
// Register indexes, register reset values and field widths.
// No dependencies.
package rsph_pkg;

	localparam int IMAGE_WIDTH  = 512;
	localparam int IMAGE_HEIGHT = 512;

	localparam int IDX_W      = 9;
	localparam int COORD_W    = 24;
	localparam int UCOORD_W   = 23;
	localparam int COLOR_W    = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_SPHERE_RADIUS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_DISTANCE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_X            = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_Y            = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_Z            = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_PITCH      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HIT_COLOR        = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_COLOR = 3'd7;

	localparam logic [UCOORD_W-1:0] RST_SPHERE_RADIUS    = 23'd12288;
	localparam logic [COORD_W-1:0]  RST_FOCAL_DISTANCE   = 24'd12288;
	localparam logic [COORD_W-1:0]  RST_CAM_X            = 24'd0;
	localparam logic [COORD_W-1:0]  RST_CAM_Y            = 24'd0;
	localparam logic [COORD_W-1:0]  RST_CAM_Z            = 24'hFF8000;
	localparam logic [UCOORD_W-1:0] RST_PIXEL_PITCH      = 23'd410;
	localparam logic [COLOR_W-1:0]  RST_HIT_COLOR        = 24'hFF0000;
	localparam logic [COLOR_W-1:0]  RST_BACKGROUND_COLOR = 24'h808080;

endpackage

// File: design/ray_sphere_pixel_hit.sv
// Ray / sphere pixel hit test: nine-stage pipeline, one pixel item per clock while not stalled.
// Each accepted item passes through registered stages 1 to 9 in order to the output.
// Throughput: 1 item per cycle without stall; out_stall holds a stage only when it and every
// stage after it are full, so empty stages keep filling while a result waits.
// Reset clears every stage valid bit and loads the register reset values.
// Depends on rsph_pkg.
module ray_sphere_pixel_hit #(
	parameter int IMAGE_WIDTH  = rsph_pkg::IMAGE_WIDTH,
	parameter int IMAGE_HEIGHT = rsph_pkg::IMAGE_HEIGHT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [rsph_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rsph_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [rsph_pkg::IDX_W-1:0]         col_index,
	input  logic [rsph_pkg::IDX_W-1:0]         row_index,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               hit,
	output logic [rsph_pkg::COLOR_W-1:0]       color
);

	localparam int MXW = $clog2(IMAGE_WIDTH) + 1;
	localparam int MYW = $clog2(IMAGE_HEIGHT) + 1;
	localparam int MW  = (MXW > MYW) ? MXW : MYW;
	localparam int DW  = MW + 24;
	localparam int PW  = DW + 1;
	localparam int SQW = DW + 26;
	localparam int UW  = SQW + 1;
	localparam int HW  = (SQW + 1) / 2;
	localparam int HIW = SQW - HW;
	localparam int HHW = 2 * HIW;
	localparam int LLW = 2 * HW;
	localparam int TW  = 2 * SQW + 2;

	// configuration registers
	logic [rsph_pkg::UCOORD_W-1:0] sphere_radius_q;
	logic [rsph_pkg::COORD_W-1:0]  focal_distance_q;
	logic [rsph_pkg::COORD_W-1:0]  cam_x_q;
	logic [rsph_pkg::COORD_W-1:0]  cam_y_q;
	logic [rsph_pkg::COORD_W-1:0]  cam_z_q;
	logic [rsph_pkg::UCOORD_W-1:0] pixel_pitch_q;
	logic [rsph_pkg::COLOR_W-1:0]  hit_color_q;
	logic [rsph_pkg::COLOR_W-1:0]  background_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sphere_radius_q    <= rsph_pkg::RST_SPHERE_RADIUS;
			focal_distance_q   <= rsph_pkg::RST_FOCAL_DISTANCE;
			cam_x_q            <= rsph_pkg::RST_CAM_X;
			cam_y_q            <= rsph_pkg::RST_CAM_Y;
			cam_z_q            <= rsph_pkg::RST_CAM_Z;
			pixel_pitch_q      <= rsph_pkg::RST_PIXEL_PITCH;
			hit_color_q        <= rsph_pkg::RST_HIT_COLOR;
			background_color_q <= rsph_pkg::RST_BACKGROUND_COLOR;
		end else if (cfg_write) begin
			case (cfg_index)
				rsph_pkg::REG_SPHERE_RADIUS:
					sphere_radius_q <= cfg_data[rsph_pkg::UCOORD_W-1:0];
				rsph_pkg::REG_FOCAL_DISTANCE:   focal_distance_q   <= cfg_data;
				rsph_pkg::REG_CAM_X:            cam_x_q            <= cfg_data;
				rsph_pkg::REG_CAM_Y:            cam_y_q            <= cfg_data;
				rsph_pkg::REG_CAM_Z:            cam_z_q            <= cfg_data;
				rsph_pkg::REG_PIXEL_PITCH:
					pixel_pitch_q <= cfg_data[rsph_pkg::UCOORD_W-1:0];
				rsph_pkg::REG_HIT_COLOR:        hit_color_q        <= cfg_data;
				rsph_pkg::REG_BACKGROUND_COLOR: background_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// doubled coordinates derived from the registers
	logic signed [24:0] cx2, cy2, cz2, f2;
	logic        [24:0] f2_mag;
	logic        [23:0] r2;
	logic signed [23:0] pitch_sx;

	assign cx2      = signed'({cam_x_q, 1'b0});
	assign cy2      = signed'({cam_y_q, 1'b0});
	assign cz2      = signed'({cam_z_q, 1'b0});
	assign f2       = signed'({focal_distance_q, 1'b0});
	assign f2_mag   = f2[24] ? 25'(-f2) : 25'(f2);
	assign r2       = {sphere_radius_q, 1'b0};
	assign pitch_sx = signed'({1'b0, pixel_pitch_q});

	// stage handshake: a stage loads when empty or when the next one loads
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9;
	logic adv_1, adv_2, adv_3, adv_4, adv_5, adv_6, adv_7, adv_8, adv_9;

	assign adv_9 = !valid_s9 || !out_stall;
	assign adv_8 = !valid_s8 || adv_9;
	assign adv_7 = !valid_s7 || adv_8;
	assign adv_6 = !valid_s6 || adv_7;
	assign adv_5 = !valid_s5 || adv_6;
	assign adv_4 = !valid_s4 || adv_5;
	assign adv_3 = !valid_s3 || adv_4;
	assign adv_2 = !valid_s2 || adv_3;
	assign adv_1 = !valid_s1 || adv_2;

	assign in_stall  = !adv_1;
	assign out_valid = valid_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			if (adv_1) valid_s1 <= in_valid;
			if (adv_2) valid_s2 <= valid_s1;
			if (adv_3) valid_s3 <= valid_s2;
			if (adv_4) valid_s4 <= valid_s3;
			if (adv_5) valid_s5 <= valid_s4;
			if (adv_6) valid_s6 <= valid_s5;
			if (adv_7) valid_s7 <= valid_s6;
			if (adv_8) valid_s8 <= valid_s7;
			if (adv_9) valid_s9 <= valid_s8;
		end
	end

	// stage 1: saturate indices, form doubled pixel offsets
	logic signed [MXW-1:0] mx_d, mx_s1;
	logic signed [MYW-1:0] my_d, my_s1;

	always_comb begin
		int col_c;
		int row_c;
		int mx_i;
		int my_i;
		col_c = (int'(col_index) > IMAGE_WIDTH - 1) ? IMAGE_WIDTH - 1 : int'(col_index);
		row_c = (int'(row_index) > IMAGE_HEIGHT - 1) ? IMAGE_HEIGHT - 1 : int'(row_index);
		mx_i  = 2 * col_c + 1 - IMAGE_WIDTH;
		my_i  = IMAGE_HEIGHT - 1 - 2 * row_c;
		mx_d  = signed'(mx_i[MXW-1:0]);
		my_d  = signed'(my_i[MYW-1:0]);
	end

	always_ff @(posedge clk) begin
		if (adv_1) begin
			mx_s1 <= mx_d;
			my_s1 <= my_d;
		end
	end

	// stage 2: scale by pixel pitch
	logic signed [DW-1:0] dx_s2, dy_s2;

	always_ff @(posedge clk) begin
		if (adv_2) begin
			dx_s2 <= DW'(mx_s1) * DW'(pitch_sx);
			dy_s2 <= DW'(my_s1) * DW'(pitch_sx);
		end
	end

	// stage 3: pixel centre and direction magnitudes
	logic signed [PW-1:0]   px_s3, py_s3;
	logic signed [25:0]     pz_s3;
	logic        [DW-2:0]   dx_mag_s3, dy_mag_s3;
	logic        [24:0]     f2_mag_s3;
	logic signed [DW-1:0]   dx_neg, dy_neg;

	assign dx_neg = -dx_s2;
	assign dy_neg = -dy_s2;

	always_ff @(posedge clk) begin
		if (adv_3) begin
			px_s3     <= PW'(dx_s2) + PW'(cx2);
			py_s3     <= PW'(dy_s2) + PW'(cy2);
			pz_s3     <= 26'(cz2) + 26'(f2);
			dx_mag_s3 <= dx_s2[DW-1] ? dx_neg[DW-2:0] : dx_s2[DW-2:0];
			dy_mag_s3 <= dy_s2[DW-1] ? dy_neg[DW-2:0] : dy_s2[DW-2:0];
			f2_mag_s3 <= f2_mag;
		end
	end

	// stage 4: cross product terms and radius-scaled direction
	logic signed [UW-1:0] term_a_s4 [3];
	logic signed [UW-1:0] term_b_s4 [3];
	logic        [SQW-1:0] rmul_s4  [3];

	always_ff @(posedge clk) begin
		if (adv_4) begin
			term_a_s4[0] <= UW'(cy2) * UW'(pz_s3);
			term_b_s4[0] <= UW'(cz2) * UW'(py_s3);
			term_a_s4[1] <= UW'(cz2) * UW'(px_s3);
			term_b_s4[1] <= UW'(cx2) * UW'(pz_s3);
			term_a_s4[2] <= UW'(cx2) * UW'(py_s3);
			term_b_s4[2] <= UW'(cy2) * UW'(px_s3);
			rmul_s4[0]   <= SQW'(r2) * SQW'(dx_mag_s3);
			rmul_s4[1]   <= SQW'(r2) * SQW'(dy_mag_s3);
			rmul_s4[2]   <= SQW'(r2) * SQW'(f2_mag_s3);
		end
	end

	// stage 5: cross product components as magnitudes
	logic [SQW-1:0] mag_d  [6];
	logic [SQW-1:0] mag_s5 [6];

	always_comb begin
		logic signed [UW-1:0] diff_ab;
		logic signed [UW-1:0] diff_ba;
		for (int i = 0; i < 3; i++) begin
			diff_ab      = term_a_s4[i] - term_b_s4[i];
			diff_ba      = term_b_s4[i] - term_a_s4[i];
			mag_d[i]     = diff_ab[UW-1] ? diff_ba[SQW-1:0] : diff_ab[SQW-1:0];
			mag_d[i + 3] = rmul_s4[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_5) begin
			for (int i = 0; i < 6; i++) begin
				mag_s5[i] <= mag_d[i];
			end
		end
	end

	// stage 6: partial products of each square
	logic [HHW-1:0] hh_s6 [6];
	logic [SQW-1:0] hl_s6 [6];
	logic [LLW-1:0] ll_s6 [6];

	always_ff @(posedge clk) begin
		if (adv_6) begin
			for (int i = 0; i < 6; i++) begin
				hh_s6[i] <= HHW'(mag_s5[i][SQW-1:HW]) * HHW'(mag_s5[i][SQW-1:HW]);
				hl_s6[i] <= SQW'(mag_s5[i][SQW-1:HW]) * SQW'(mag_s5[i][HW-1:0]);
				ll_s6[i] <= LLW'(mag_s5[i][HW-1:0]) * LLW'(mag_s5[i][HW-1:0]);
			end
		end
	end

	// stage 7: sum like partial products per side
	logic [HHW+1:0] hh_sum_s7 [2];
	logic [SQW+1:0] hl_sum_s7 [2];
	logic [LLW+1:0] ll_sum_s7 [2];

	always_ff @(posedge clk) begin
		if (adv_7) begin
			for (int j = 0; j < 2; j++) begin
				hh_sum_s7[j] <= (HHW+2)'(hh_s6[3*j]) + (HHW+2)'(hh_s6[3*j+1])
					+ (HHW+2)'(hh_s6[3*j+2]);
				hl_sum_s7[j] <= (SQW+2)'(hl_s6[3*j]) + (SQW+2)'(hl_s6[3*j+1])
					+ (SQW+2)'(hl_s6[3*j+2]);
				ll_sum_s7[j] <= (LLW+2)'(ll_s6[3*j]) + (LLW+2)'(ll_s6[3*j+1])
					+ (LLW+2)'(ll_s6[3*j+2]);
			end
		end
	end

	// stage 8: assemble full sums of squares
	logic [TW-1:0] total_s8 [2];

	always_ff @(posedge clk) begin
		if (adv_8) begin
			for (int j = 0; j < 2; j++) begin
				total_s8[j] <= (TW'(hh_sum_s7[j]) << (2 * HW))
					+ (TW'(hl_sum_s7[j]) << (HW + 1)) + TW'(ll_sum_s7[j]);
			end
		end
	end

	// stage 9: compare and pick color
	logic                          hit_s9;
	logic [rsph_pkg::COLOR_W-1:0]  color_s9;
	logic                          hit_d;

	assign hit_d = total_s8[0] <= total_s8[1];

	always_ff @(posedge clk) begin
		if (adv_9) begin
			hit_s9   <= hit_d;
			color_s9 <= hit_d ? hit_color_q : background_color_q;
		end
	end

	assign hit   = hit_s9;
	assign color = color_s9;

endmodule
